>>> rtl/core/hmtq_pkg.sv
// ----------------------------------------------------------------------------
// hmtq_pkg
// Shared types and constants of the min-heap timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hmtq_pkg;

  // heap geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;

  // input item kinds
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // one heap entry
  typedef struct packed {
    logic [TIME_W-1:0] trig;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // memory access request: one write, two read addresses
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } ram_req_t;

  // one result beat
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] trig;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } out_beat_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_CHK,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/hmtq_in_if.sv
// ----------------------------------------------------------------------------
// hmtq_in_if
// Command channel: add event or tick with current time.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmtq_in_if;
  import hmtq_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIME_W-1:0] trigger_time;
  logic [TAG_W-1:0]  event_tag;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output mode, output trigger_time, output event_tag,
                  output now_time, input ready);
  modport sink (input valid, input mode, input trigger_time, input event_tag,
                input now_time, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hmtq_out_if.sv
// ----------------------------------------------------------------------------
// hmtq_out_if
// Result channel: one beat per fired event.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmtq_out_if;
  import hmtq_pkg::*;

  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  fired_tag;
  logic [TIME_W-1:0] fired_time;
  logic [CNT_W-1:0]  pending_count;
  logic              last_of_run;

  modport source (output valid, output fired_tag, output fired_time,
                  output pending_count, output last_of_run, input ready);
  modport sink (input valid, input fired_tag, input fired_time,
                input pending_count, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/min_heap_timer_queue.sv
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Timer event queue kept as a binary min-heap on trigger time.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per beat. mode 0 adds (trigger_time, event_tag);
//   it gives no result and is dropped silently when the heap is full.
//   mode 1 is a tick: every entry with time at or below now_time is popped
//   in heap order, one beat on fired each, last_of_run set on the final one.
//   A tick with nothing due gives no beat.
// Sequencing:
//   The heap lives in one memory with two registered read ports; each heap
//   level costs a read step and a compare/write step. A tick reads the root
//   and the last entry and tests the root against now_time. Each pop then
//   sifts the last entry down from the root, tests the new root and hands
//   the beat over; every pop but the last reads the root again.
//   cmd.ready is high only while no item is in work.
// Reset and stall:
//   rst empties the heap; memory contents are not cleared. A stalled
//   receiver holds the sequencer at the hand-over step; the last beat of a
//   run waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_timer_queue
  import hmtq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  hmtq_in_if.sink    cmd,
  hmtq_out_if.source fired
);

  ram_req_t  req;
  entry_t    rd_a;
  entry_t    rd_b;
  logic      can_take;
  logic      load;
  out_beat_t beat;

  // heap storage
  hmtq_ram u_ram (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // sift sequencer
  hmtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .req      (req),
    .can_take (can_take),
    .load     (load),
    .beat     (beat)
  );

  // result register
  hmtq_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .beat_in  (beat),
    .can_take (can_take),
    .fired    (fired)
  );

endmodule

`default_nettype wire

>>> rtl/core/hmtq_ram.sv
// ----------------------------------------------------------------------------
// hmtq_ram
// Heap storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtq_ram
  import hmtq_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output entry_t        rd_a,
  output entry_t        rd_b
);

  entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

`default_nettype wire

>>> rtl/core/hmtq_out_reg.sv
// ----------------------------------------------------------------------------
// hmtq_out_reg
// Output register that holds one result beat toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtq_out_reg
  import hmtq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_beat_t beat_in,
  output logic           can_take,
  hmtq_out_if.source     fired
);

  logic      valid;
  out_beat_t beat;

  assign can_take = !valid || fired.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_take && load) begin
      beat <= beat_in;
    end
  end

  assign fired.valid         = valid;
  assign fired.fired_tag     = beat.tag;
  assign fired.fired_time    = beat.trig;
  assign fired.pending_count = beat.cnt;
  assign fired.last_of_run   = beat.last;

endmodule

`default_nettype wire

>>> rtl/core/hmtq_ctrl.sv
// ----------------------------------------------------------------------------
// hmtq_ctrl
// Heap sequencer: sift-up on add, pop and sift-down on tick.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtq_ctrl
  import hmtq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  hmtq_in_if.sink    cmd,
  input  wire entry_t rd_a,
  input  wire entry_t rd_b,
  output ram_req_t   req,
  input  wire logic  can_take,
  output logic       load,
  output out_beat_t  beat
);

  localparam int PW = IDX_W + 1;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  pos, pos_next;
  entry_t            x, x_next;
  logic [TIME_W-1:0] now_t, now_t_next;
  entry_t            res, res_next;
  logic [CNT_W-1:0]  res_cnt, res_cnt_next;
  logic              res_held, res_held_next;
  logic              more_due, more_due_next;

  logic              accept;
  logic              full;
  logic              due;
  logic [PW-1:0]     left_w, right_w;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W-1:0]  last_idx;
  logic              take_l, take_r;
  logic [TIME_W-1:0] best_t;

  assign accept   = cmd.valid && cmd.ready;
  assign full     = count >= CNT_W'(CAPACITY);
  assign due      = (count != '0) && (rd_a.trig <= now_t);
  assign left_w   = {pos, 1'b1};
  assign right_w  = PW'({pos, 1'b0}) + PW'(2);
  assign parent   = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign last_idx = IDX_W'(count - CNT_W'(1));

  // child selection, left wins ties
  assign take_l = rd_a.trig < x.trig;
  assign best_t = take_l ? rd_a.trig : x.trig;
  assign take_r = (CNT_W'(right_w) < count) && (rd_b.trig < best_t);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.mode == MODE_TICK) begin
            state_next = S_POP_RD;
          end else if (!full) begin
            state_next = S_UP_RD;
          end
        end
      end
      S_UP_RD:  state_next = (pos == '0) ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_next = (rd_a.trig > x.trig) ? S_UP_RD : S_IDLE;
      S_POP_RD: state_next = S_POP_CHK;
      S_POP_CHK: begin
        if (res_held) begin
          state_next = S_EMIT;
        end else if (!due) begin
          state_next = S_IDLE;
        end else if (count == CNT_W'(1)) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_DN_RD:  state_next = (CNT_W'(left_w) >= count) ? S_POP_RD : S_DN_CMP;
      S_DN_CMP: state_next = (take_r || take_l) ? S_DN_RD : S_POP_RD;
      S_EMIT: begin
        if (can_take) begin
          state_next = more_due ? S_POP_RD : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next    = count;
    pos_next      = pos;
    x_next        = x;
    now_t_next    = now_t;
    res_next      = res;
    res_cnt_next  = res_cnt;
    res_held_next = res_held;
    more_due_next = more_due;
    req           = '0;
    load          = 1'b0;
    cmd.ready     = (state == S_IDLE);
    beat.tag      = res.tag;
    beat.trig     = res.trig;
    beat.cnt      = res_cnt;
    beat.last     = !more_due;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.mode == MODE_TICK) begin
            now_t_next    = cmd.now_time;
            res_held_next = 1'b0;
            more_due_next = 1'b0;
          end else if (!full) begin
            x_next.trig = cmd.trigger_time;
            x_next.tag  = cmd.event_tag;
            pos_next    = IDX_W'(count);
            count_next  = count + CNT_W'(1);
          end
        end
      end
      // climb: read parent, or settle at the root
      S_UP_RD: begin
        req.raddr_a = parent;
        if (pos == '0) begin
          req.we    = 1'b1;
          req.waddr = pos;
          req.wdata = x;
        end
      end
      S_UP_CMP: begin
        req.we    = 1'b1;
        req.waddr = pos;
        if (rd_a.trig > x.trig) begin
          req.wdata = rd_a;
          pos_next  = parent;
        end else begin
          req.wdata = x;
        end
      end
      // fetch root and last entry
      S_POP_RD: begin
        req.raddr_a = '0;
        req.raddr_b = last_idx;
      end
      S_POP_CHK: begin
        if (res_held) begin
          more_due_next = due;
        end else if (due) begin
          res_next      = rd_a;
          count_next    = count - CNT_W'(1);
          res_cnt_next  = count - CNT_W'(1);
          res_held_next = 1'b1;
          x_next        = rd_b;
          pos_next      = '0;
        end
      end
      // sink: read both children, or settle when there are none
      S_DN_RD: begin
        req.raddr_a = IDX_W'(left_w);
        req.raddr_b = IDX_W'(right_w);
        if (CNT_W'(left_w) >= count) begin
          req.we    = 1'b1;
          req.waddr = pos;
          req.wdata = x;
        end
      end
      S_DN_CMP: begin
        req.we    = 1'b1;
        req.waddr = pos;
        if (take_r) begin
          req.wdata = rd_b;
          pos_next  = IDX_W'(right_w);
        end else if (take_l) begin
          req.wdata = rd_a;
          pos_next  = IDX_W'(left_w);
        end else begin
          req.wdata = x;
        end
      end
      S_EMIT: begin
        load = 1'b1;
        if (can_take) begin
          res_held_next = 1'b0;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      res_held <= 1'b0;
      more_due <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      res_held <= res_held_next;
      more_due <= more_due_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    x       <= x_next;
    now_t   <= now_t_next;
    res     <= res_next;
    res_cnt <= res_cnt_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/hmtq_checker.sv
// ----------------------------------------------------------------------------
// hmtq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtq_checker
  import hmtq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cmd_valid,
  input wire logic              cmd_ready,
  input wire logic              cmd_mode,
  input wire logic              fired_valid,
  input wire logic              fired_ready,
  input wire logic [TAG_W-1:0]  fired_tag,
  input wire logic [TIME_W-1:0] fired_time,
  input wire logic [CNT_W-1:0]  fired_count,
  input wire logic              fired_last
);

  // a waiting beat stays until taken
  a_fired_hold: assert property (@(posedge clk) disable iff (rst)
    fired_valid && !fired_ready |=> fired_valid)
    else $error("fired beat dropped while stalled");

  // a waiting beat keeps its payload
  a_fired_stable: assert property (@(posedge clk) disable iff (rst)
    fired_valid && !fired_ready |=>
      $stable(fired_tag) && $stable(fired_time) && $stable(fired_count)
      && $stable(fired_last))
    else $error("fired payload changed while stalled");

  // a tick keeps the block busy for at least the root test
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_mode == MODE_TICK) |=> !cmd_ready)
    else $error("ready right after a tick");

  // remaining count never exceeds the heap size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fired_valid |-> fired_count < CNT_W'(CAPACITY))
    else $error("pending count out of range");

  // no beat appears straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !fired_valid)
    else $error("fired beat right after reset");

endmodule

bind min_heap_timer_queue hmtq_checker u_hmtq_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_mode    (cmd.mode),
  .fired_valid (fired.valid),
  .fired_ready (fired.ready),
  .fired_tag   (fired.fired_tag),
  .fired_time  (fired.fired_time),
  .fired_count (fired.pending_count),
  .fired_last  (fired.last_of_run)
);

`default_nettype wire

>>> tb/hmtq_fire_check.sv
// ----------------------------------------------------------------------------
// hmtq_fire_check
// Watches the command and fired channels of the timer queue, keeps its own
// copy of the min-heap, and checks every fired beat field by field against
// the entries the heap says are due, in order.
// ----------------------------------------------------------------------------
module hmtq_fire_check
  import hmtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hmtq_in_if          cmd,
  hmtq_out_if         fired,
  output int unsigned fail_count,
  output int unsigned beats_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow heap and the beats it says are due
  entry_t      heap_mem [CAPACITY];
  int unsigned heap_fill;
  out_beat_t   due_fires [$];

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // apply one command beat to the shadow heap, queue the beats it fires
  function automatic void apply_cmd(logic mode, logic [TIME_W-1:0] trig,
                                    logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now);
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    out_beat_t   beat;
    if (mode == MODE_ADD) begin
      // full heap drops the add without a trace
      if (heap_fill >= CAPACITY) return;
      pos                = heap_fill;
      heap_mem[pos].trig = trig;
      heap_mem[pos].tag  = tag;
      heap_fill++;
      // climb while the parent is strictly later
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_mem[up].trig <= heap_mem[pos].trig) break;
        swap_slots(up, pos);
        pos = up;
      end
      return;
    end
    // tick: pop every root that is due
    while (heap_fill > 0 && heap_mem[0].trig <= now) begin
      beat.tag  = heap_mem[0].tag;
      beat.trig = heap_mem[0].trig;
      heap_fill--;
      heap_mem[0] = heap_mem[heap_fill];
      // sink toward the strictly smaller child, left wins a tie
      pos = 0;
      forever begin
        best = pos;
        lc   = 2 * pos + 1;
        if (lc < heap_fill && heap_mem[lc].trig < heap_mem[best].trig) best = lc;
        if (lc + 1 < heap_fill && heap_mem[lc + 1].trig < heap_mem[best].trig)
          best = lc + 1;
        if (best == pos) break;
        swap_slots(best, pos);
        pos = best;
      end
      beat.cnt  = CNT_W'(heap_fill);
      beat.last = !(heap_fill > 0 && heap_mem[0].trig <= now);
      due_fires.push_back(beat);
    end
  endfunction

  function automatic void flag_field(string field, logic [TIME_W-1:0] want,
                                     logic [TIME_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  // sample both channels at each edge
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      heap_fill  = 0;
      fail_count = 0;
      due_fires.delete();
    end else begin
      // compare a fired beat with the oldest due entry
      if (fired.valid && fired.ready) begin
        if (due_fires.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual tag %h time %h",
                   $time, fired.fired_tag, fired.fired_time);
        end else begin
          want = due_fires.pop_front();
          if (fired.fired_tag !== want.tag)
            flag_field("fired_tag", TIME_W'(want.tag), TIME_W'(fired.fired_tag));
          if (fired.fired_time !== want.trig)
            flag_field("fired_time", want.trig, fired.fired_time);
          if (fired.pending_count !== want.cnt)
            flag_field("pending_count", TIME_W'(want.cnt),
                       TIME_W'(fired.pending_count));
          if (fired.last_of_run !== want.last)
            flag_field("last_of_run", TIME_W'(want.last),
                       TIME_W'(fired.last_of_run));
        end
      end
      if (cmd.valid && cmd.ready)
        apply_cmd(cmd.mode, cmd.trigger_time, cmd.event_tag, cmd.now_time);
    end
    beats_waiting = due_fires.size();
  end

endmodule

>>> tb/min_heap_timer_queue_test.sv
// ----------------------------------------------------------------------------
// min_heap_timer_queue_test
// Drives adds and ticks into the timer queue under varying idle patterns,
// fills and overflows the heap, backs up the fired side, and reports the
// verdict from the failure count of the fired-beat checker.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_test;
  import hmtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatches;
  int unsigned beats_waiting;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  bit          hold_req;
  logic [TIME_W-1:0] clock_base;

  hmtq_in_if  cmd_if ();
  hmtq_out_if fired_if ();

  min_heap_timer_queue dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .fired (fired_if)
  );

  hmtq_fire_check fire_check (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_if),
    .fired         (fired_if),
    .fail_count    (mismatches),
    .beats_waiting (beats_waiting)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // fired side: random stalls, or a long hold-off when asked
  initial begin
    fired_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        fired_if.ready <= 1'b0;
      end else begin
        fired_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one beat, valid stays up afterwards unless a gap follows
  task automatic send_item(input logic mode, input logic [TIME_W-1:0] trig,
                           input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.mode         <= mode;
    cmd_if.trigger_time <= trig;
    cmd_if.event_tag    <= tag;
    cmd_if.now_time     <= now;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  task automatic add_event(input logic [TIME_W-1:0] trig, input logic [TAG_W-1:0] tag);
    send_item(MODE_ADD, trig, tag, $urandom);
  endtask

  task automatic tick(input logic [TIME_W-1:0] now);
    send_item(MODE_TICK, $urandom, TAG_W'($urandom), now);
  endtask

  // drop valid and wait for every due beat to arrive
  task automatic await_drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    wait (beats_waiting == 0);
  endtask

  // mostly near the running clock so ticks find work, sometimes anywhere
  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return clock_base + $urandom_range(0, 40);
  endfunction

  // bursts of adds closed by a tick, with noise ticks and full drains
  task automatic run_random(input int unsigned n_items, input int unsigned s_pct,
                            input int unsigned r_pct);
    int unsigned sent;
    int unsigned pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent          = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(0, 10)) begin
        add_event(pick_time(), TAG_W'($urandom));
        sent++;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        tick($urandom);
      end else if (pick == 1) begin
        tick('1);
      end else begin
        clock_base += $urandom_range(0, 25);
        tick(clock_base);
      end
      sent++;
    end
    await_drain();
  endtask

  initial begin
    cmd_if.valid        <= 1'b0;
    cmd_if.mode         <= MODE_ADD;
    cmd_if.trigger_time <= '0;
    cmd_if.event_tag    <= '0;
    cmd_if.now_time     <= '0;
    rst                 <= 1'b1;
    hold_req      = 1'b0;
    clock_base    = 32'd100;
    send_idle_pct = 12;
    recv_idle_pct = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty heap: nothing due even at the latest time
    tick('1);
    // extremes of time and tag, ties on time
    send_item(MODE_ADD, '0, '0, '1);
    send_item(MODE_ADD, '1, '1, '0);
    add_event(32'd5, 16'h1234);
    add_event(32'd5, 16'hABCD);
    add_event(32'd5, 16'h0F0F);
    add_event(32'd3, 16'h5555);
    // unused fields at their extremes on a tick
    send_item(MODE_TICK, '1, '1, '0);
    // root later than now
    tick(32'd2);
    tick(32'd5);
    tick(32'hFFFF_FFFE);
    tick('1);
    // descending adds climb to the root every time
    for (int unsigned k = 20; k > 12; k--) add_event(k, TAG_W'(k));
    tick(32'd16);
    tick('1);
    await_drain();

    run_random(45, 12, 70);

    // empty, fill to capacity, then overflow
    tick('1);
    repeat (CAPACITY) add_event(pick_time(), TAG_W'($urandom));
    repeat (3) add_event(pick_time(), TAG_W'($urandom));
    // hold the fired side while the full drain backs up into the command side
    hold_req = 1'b1;
    tick('1);
    repeat (8) add_event(pick_time(), TAG_W'($urandom));
    await_drain();

    run_random(45, 70, 12);
    run_random(30, 0, 0);

    await_drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hmtq_pkg.sv
rtl/core/hmtq_in_if.sv
rtl/core/hmtq_out_if.sv
rtl/core/hmtq_ram.sv
rtl/core/hmtq_out_reg.sv
rtl/core/hmtq_ctrl.sv
rtl/core/min_heap_timer_queue.sv
rtl/core/hmtq_checker.sv
tb/hmtq_fire_check.sv
tb/min_heap_timer_queue_test.sv
